// ===== hdl/iirdf1_pkg.sv =====
package iirdf1_pkg;

    localparam int COEF_BITS  = 18;
    localparam int FRAC_SHIFT = 14;
    // headroom for five products
    localparam int ACC_GUARD  = 3;
    localparam int HIST_DEPTH = 2;
    localparam int NUM_REGS   = 5;
    localparam int ADDR_W     = 5;
    localparam int DATA_W     = 32;

    typedef logic signed [COEF_BITS-1:0] coef_t;

    typedef enum logic [2:0] {
        REG_B0 = 3'd0,
        REG_B1 = 3'd1,
        REG_B2 = 3'd2,
        REG_A1 = 3'd3,
        REG_A2 = 3'd4
    } reg_idx_t;

    typedef struct packed {
        coef_t b0;
        coef_t b1;
        coef_t b2;
        coef_t a1;
        coef_t a2;
    } coef_set_t;

    localparam coef_t B0_RESET = 18'sd16384;

endpackage

// ===== hdl/iirdf1_stream_if.sv =====
interface iirdf1_in_if #(
    parameter int W = 16
);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink (input valid, input sample_in, output ready);
endinterface

interface iirdf1_out_if #(
    parameter int W = 16
);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] sample_out;
    logic                saturated;

    modport source (output valid, output sample_out, output saturated, input ready);
    modport sink (input valid, input sample_out, input saturated, output ready);
endinterface

// ===== hdl/iirdf1_apb_regs.sv =====
module iirdf1_apb_regs (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [iirdf1_pkg::ADDR_W-1:0]     paddr,
    input  logic [iirdf1_pkg::DATA_W-1:0]     pwdata,
    output logic [iirdf1_pkg::DATA_W-1:0]     prdata,
    output logic                              pready,
    output iirdf1_pkg::coef_set_t             coefs
);

    localparam int EXT_W = iirdf1_pkg::DATA_W - iirdf1_pkg::COEF_BITS;

    iirdf1_pkg::coef_set_t coef_reg;
    iirdf1_pkg::coef_set_t coef_next;
    iirdf1_pkg::coef_t     wr_coef;
    iirdf1_pkg::coef_t     rd_coef;
    logic [2:0]            reg_idx;
    logic                  wr_en;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[iirdf1_pkg::ADDR_W-1:2];
    assign wr_coef = iirdf1_pkg::coef_t'(pwdata[iirdf1_pkg::COEF_BITS-1:0]);

    always_comb
    begin
        coef_next = coef_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                iirdf1_pkg::REG_B0: coef_next.b0 = wr_coef;
                iirdf1_pkg::REG_B1: coef_next.b1 = wr_coef;
                iirdf1_pkg::REG_B2: coef_next.b2 = wr_coef;
                iirdf1_pkg::REG_A1: coef_next.a1 = wr_coef;
                iirdf1_pkg::REG_A2: coef_next.a2 = wr_coef;
                default:            coef_next = coef_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            iirdf1_pkg::REG_B0: rd_coef = coef_reg.b0;
            iirdf1_pkg::REG_B1: rd_coef = coef_reg.b1;
            iirdf1_pkg::REG_B2: rd_coef = coef_reg.b2;
            iirdf1_pkg::REG_A1: rd_coef = coef_reg.a1;
            iirdf1_pkg::REG_A2: rd_coef = coef_reg.a2;
            default:            rd_coef = '0;
        endcase
    end

    assign prdata = {{EXT_W{rd_coef[iirdf1_pkg::COEF_BITS-1]}}, rd_coef};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg.b0 <= iirdf1_pkg::B0_RESET;
            coef_reg.b1 <= '0;
            coef_reg.b2 <= '0;
            coef_reg.a1 <= '0;
            coef_reg.a2 <= '0;
        end
        else
        begin
            coef_reg <= coef_next;
        end
    end

    assign coefs = coef_reg;

endmodule

// ===== hdl/iirdf1_tap_cell.sv =====
module iirdf1_tap_cell #(
    parameter int W     = 16,
    parameter bit USE_B = 1'b1,
    parameter bit USE_A = 1'b1
) (
    input  logic                                              clk,
    input  logic                                              rst_n,
    input  logic                                              advance,
    input  logic signed [W-1:0]                               x_in,
    input  logic signed [W-1:0]                               y_in,
    input  iirdf1_pkg::coef_t                                 coef_b,
    input  iirdf1_pkg::coef_t                                 coef_a,
    input  logic signed [iirdf1_pkg::COEF_BITS+W+iirdf1_pkg::ACC_GUARD-1:0] acc_in,
    output logic signed [iirdf1_pkg::COEF_BITS+W+iirdf1_pkg::ACC_GUARD-1:0] acc_out,
    output logic signed [W-1:0]                               x_out,
    output logic signed [W-1:0]                               y_out
);

    localparam int PROD_W = iirdf1_pkg::COEF_BITS + W;
    localparam int ACC_W  = PROD_W + iirdf1_pkg::ACC_GUARD;

    logic signed [W-1:0]      x_reg;
    logic signed [W-1:0]      x_next;
    logic signed [W-1:0]      y_reg;
    logic signed [W-1:0]      y_next;
    logic signed [PROD_W-1:0] prod_b;
    logic signed [PROD_W-1:0] prod_a;
    logic signed [ACC_W-1:0]  ext_b;
    logic signed [ACC_W-1:0]  ext_a;

    // cell holds one step of both histories; it shifts with every accepted item
    assign x_next = advance ? x_in : x_reg;
    assign y_next = advance ? y_in : y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg <= '0;
            y_reg <= '0;
        end
        else
        begin
            x_reg <= x_next;
            y_reg <= y_next;
        end
    end

    assign prod_b = USE_B ? PROD_W'(coef_b * x_reg) : '0;
    assign prod_a = USE_A ? PROD_W'(coef_a * y_reg) : '0;
    assign ext_b  = {{iirdf1_pkg::ACC_GUARD{prod_b[PROD_W-1]}}, prod_b};
    assign ext_a  = {{iirdf1_pkg::ACC_GUARD{prod_a[PROD_W-1]}}, prod_a};

    assign acc_out = acc_in + ext_b - ext_a;
    assign x_out   = x_reg;
    assign y_out   = y_reg;

endmodule

// ===== hdl/iirdf1_round_sat.sv =====
module iirdf1_round_sat #(
    parameter int W = 16
) (
    input  logic signed [iirdf1_pkg::COEF_BITS+W+iirdf1_pkg::ACC_GUARD-1:0] acc,
    output logic signed [W-1:0]                                              y,
    output logic                                                             sat
);

    localparam int ACC_W = iirdf1_pkg::COEF_BITS + W + iirdf1_pkg::ACC_GUARD;
    localparam int RW    = ACC_W - iirdf1_pkg::FRAC_SHIFT;

    localparam logic signed [ACC_W-1:0] HALF =
        ACC_W'(1) << (iirdf1_pkg::FRAC_SHIFT - 1);
    localparam logic signed [RW-1:0] SAT_HI = {{(RW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [RW-1:0] SAT_LO = {{(RW-W+1){1'b1}}, {(W-1){1'b0}}};

    logic signed [ACC_W-1:0] biased;
    logic signed [RW-1:0]    rounded;

    // half up: add half an LSB, then drop the fraction (floor)
    assign biased  = acc + HALF;
    assign rounded = biased[ACC_W-1:iirdf1_pkg::FRAC_SHIFT];

    always_comb
    begin
        if (rounded > SAT_HI)
        begin
            y   = SAT_HI[W-1:0];
            sat = 1'b1;
        end
        else if (rounded < SAT_LO)
        begin
            y   = SAT_LO[W-1:0];
            sat = 1'b1;
        end
        else
        begin
            y   = rounded[W-1:0];
            sat = 1'b0;
        end
    end

endmodule

// ===== hdl/iir_direct_form_one_filter.sv =====
// Second-order direct form I IIR filter (biquad).
// y = b0*x + b1*x[n-1] + b2*x[n-2] - a1*y[n-1] - a2*y[n-2], samples Q1.15,
// coefficients Q4.14 already normalized by the leading denominator term.
// Channels: sample_ch takes one input item (sample_in) per valid/ready
// handshake; result_ch delivers one result item (sample_out, saturated) for
// each input item, in order. Coefficients are written over the APB port at
// byte address 4*i (b0, b1, b2, a1, a2); write only while the filter is idle.
// A result appears on result_ch in the cycle after its input item is
// accepted. Throughput: one item per cycle while each result is taken. The
// whole feedback path (products, the sum through the two tap cells, rounding
// and saturation) is combinational: the next item needs the new output.
// Stall: the result sits in an output register; while it is not taken,
// sample_ch.ready drops, and it rises in the same cycle result_ch.ready does.
// Reset (rst_n, async, active low): histories clear to zero, no result is
// pending, b0 = 1.0 and all other coefficients are zero (pass-through).
module iir_direct_form_one_filter #(
    parameter int NUM_TAPS    = 3,
    parameter int DEN_TAPS    = 3,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    iirdf1_in_if.sink                     sample_ch,
    iirdf1_out_if.source                  result_ch,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [iirdf1_pkg::ADDR_W-1:0] paddr,
    input  logic [iirdf1_pkg::DATA_W-1:0] pwdata,
    output logic [iirdf1_pkg::DATA_W-1:0] prdata,
    output logic                          pready
);

    localparam int W      = SAMPLE_BITS;
    localparam int PROD_W = iirdf1_pkg::COEF_BITS + W;
    localparam int ACC_W  = PROD_W + iirdf1_pkg::ACC_GUARD;
    localparam int HD     = iirdf1_pkg::HIST_DEPTH;

    iirdf1_pkg::coef_set_t coefs;
    iirdf1_pkg::coef_t     coef_b_tap [1:HD];
    iirdf1_pkg::coef_t     coef_a_tap [1:HD];

    logic signed [W-1:0]      x_tap [0:HD];
    logic signed [W-1:0]      y_tap [0:HD];
    logic signed [ACC_W-1:0]  acc_chain [0:HD];
    logic signed [PROD_W-1:0] prod_b0;
    logic signed [W-1:0]      y_new;
    logic                     sat_new;
    logic                     advance;

    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic signed [W-1:0]      out_sample_reg;
    logic                     out_sat_reg;

    iirdf1_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .coefs   (coefs)
    );

    assign coef_b_tap[1] = coefs.b1;
    assign coef_b_tap[2] = coefs.b2;
    assign coef_a_tap[1] = coefs.a1;
    assign coef_a_tap[2] = coefs.a2;

    assign sample_ch.ready = !out_valid_reg || result_ch.ready;
    assign advance         = sample_ch.valid && sample_ch.ready;

    assign prod_b0      = PROD_W'(coefs.b0 * sample_ch.sample_in);
    assign acc_chain[0] = {{iirdf1_pkg::ACC_GUARD{prod_b0[PROD_W-1]}}, prod_b0};
    assign x_tap[0]     = sample_ch.sample_in;
    // the new saturated output enters the feedback line at the first cell
    assign y_tap[0]     = y_new;

    for (genvar k = 1; k <= HD; k++)
    begin : g_cell
        iirdf1_tap_cell #(
            .W     (W),
            .USE_B (k < NUM_TAPS),
            .USE_A (k < DEN_TAPS)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .advance (advance),
            .x_in    (x_tap[k-1]),
            .y_in    (y_tap[k-1]),
            .coef_b  (coef_b_tap[k]),
            .coef_a  (coef_a_tap[k]),
            .acc_in  (acc_chain[k-1]),
            .acc_out (acc_chain[k]),
            .x_out   (x_tap[k]),
            .y_out   (y_tap[k])
        );
    end

    iirdf1_round_sat #(
        .W (W)
    ) u_round (
        .acc (acc_chain[HD]),
        .y   (y_new),
        .sat (sat_new)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_sample_reg <= y_new;
            out_sat_reg    <= sat_new;
        end
    end

    assign result_ch.valid      = out_valid_reg;
    assign result_ch.sample_out = out_sample_reg;
    assign result_ch.saturated  = out_sat_reg;

`ifndef NO_ASSERTIONS
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> result_ch.valid)
        else $error("accepted item produced no result");

    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (result_ch.valid && !result_ch.ready) |-> !sample_ch.ready)
        else $error("input taken while result stalled");

    a_x_shift: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (x_tap[1] == $past(sample_ch.sample_in)))
        else $error("input history did not shift");

    a_y_feedback: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (y_tap[1] == result_ch.sample_out))
        else $error("feedback history differs from delivered result");

    a_sat_rails: assert property (@(posedge clk) disable iff (!rst_n)
        (result_ch.valid && result_ch.saturated) |->
            ((result_ch.sample_out == {1'b0, {(W-1){1'b1}}}) ||
             (result_ch.sample_out == {1'b1, {(W-1){1'b0}}})))
        else $error("saturated result not at a rail");
`endif

endmodule

// ===== verif/iirdf1_filter_checker.sv =====
`timescale 1ns / 1ps
module iirdf1_filter_checker
    import iirdf1_pkg::*;
#(
    parameter int SW = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_ready,
    input  logic signed [SW-1:0] in_sample,
    input  logic                 out_valid,
    input  logic                 out_ready,
    input  logic signed [SW-1:0] out_sample,
    input  logic                 out_saturated,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic                 pready,
    input  logic [ADDR_W-1:0]    paddr,
    input  logic [DATA_W-1:0]    pwdata,
    output int                   mismatch_count,
    output int                   outstanding
);

    typedef struct packed {
        logic signed [SW-1:0] sample;
        logic                 saturated;
    } filt_result_t;

    coef_t                b0, b1, b2, a1, a2;
    logic signed [SW-1:0] x_hist [HIST_DEPTH];
    logic signed [SW-1:0] y_hist [HIST_DEPTH];
    filt_result_t         pending_outputs [$];
    int                   errs;

    // exact sum, round half up to Q1.15, clip to the sample range
    function automatic filt_result_t biquad_response(input logic signed [SW-1:0] x);
        longint       acc;
        longint       rounded;
        longint       top_val;
        longint       bot_val;
        filt_result_t res;
        top_val = (longint'(1) <<< (SW - 1)) - 1;
        bot_val = -top_val - 1;
        acc = longint'(b0) * longint'(x)
            + longint'(b1) * longint'(x_hist[0])
            + longint'(b2) * longint'(x_hist[1])
            - longint'(a1) * longint'(y_hist[0])
            - longint'(a2) * longint'(y_hist[1]);
        rounded = (acc + (longint'(1) <<< (FRAC_SHIFT - 1))) >>> FRAC_SHIFT;
        res.saturated = 1'b0;
        if (rounded > top_val)
        begin
            rounded       = top_val;
            res.saturated = 1'b1;
        end
        else if (rounded < bot_val)
        begin
            rounded       = bot_val;
            res.saturated = 1'b1;
        end
        res.sample = rounded[SW-1:0];
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        filt_result_t want;
        filt_result_t fresh;
        if (!rst_n)
        begin
            b0 = B0_RESET;
            b1 = '0;
            b2 = '0;
            a1 = '0;
            a2 = '0;
            for (int i = 0; i < HIST_DEPTH; i++)
            begin
                x_hist[i] = '0;
                y_hist[i] = '0;
            end
            pending_outputs.delete();
            errs = 0;
            outstanding    <= 0;
            mismatch_count <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[ADDR_W-1:2])
                    REG_B0:  b0 = $signed(pwdata[COEF_BITS-1:0]);
                    REG_B1:  b1 = $signed(pwdata[COEF_BITS-1:0]);
                    REG_B2:  b2 = $signed(pwdata[COEF_BITS-1:0]);
                    REG_A1:  a1 = $signed(pwdata[COEF_BITS-1:0]);
                    REG_A2:  a2 = $signed(pwdata[COEF_BITS-1:0]);
                    default: ;  // unmapped index, write dropped
                endcase
            end

            // results leave before the item accepted at this edge is queued
            if (out_valid && out_ready)
            begin
                if (pending_outputs.size() == 0)
                begin
                    errs++;
                    if (errs <= 10)
                        $display("%0t: unexpected result sample_out=%0d saturated=%0b",
                                 $time, out_sample, out_saturated);
                end
                else
                begin
                    want = pending_outputs.pop_front();
                    if (out_sample !== want.sample || out_saturated !== want.saturated)
                    begin
                        errs++;
                        if (errs <= 10)
                            $display("%0t: sample_out exp %0d got %0d, saturated exp %0b got %0b",
                                     $time, $signed(want.sample), out_sample,
                                     want.saturated, out_saturated);
                    end
                end
            end

            if (in_valid && in_ready)
            begin
                fresh = biquad_response(in_sample);
                pending_outputs.push_back(fresh);
                x_hist[1] = x_hist[0];
                x_hist[0] = in_sample;
                y_hist[1] = y_hist[0];
                y_hist[0] = fresh.sample;
            end

            outstanding    <= pending_outputs.size();
            mismatch_count <= errs;
        end
    end

endmodule

// ===== verif/tb_iir_direct_form_one_filter.sv =====
`timescale 1ns / 1ps
module tb_iir_direct_form_one_filter;
    import iirdf1_pkg::*;

    localparam int SW          = 16;
    localparam int GAP_PCT     = 13;
    localparam int RAND_PHASES = 12;
    localparam int PHASE_ITEMS = 155;
    localparam int QUIET_PHASE = 4;
    localparam int COEF_MAX    = 131071;
    localparam int COEF_MIN    = -131072;
    localparam int UNITY       = 16384;

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              no_gaps;
    int                mismatch_count;
    int                outstanding;

    iirdf1_in_if  #(.W(SW)) sample_ch ();
    iirdf1_out_if #(.W(SW)) result_ch ();

    iir_direct_form_one_filter DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample_ch (sample_ch),
        .result_ch (result_ch),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    iirdf1_filter_checker #(.SW(SW)) response_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (sample_ch.valid),
        .in_ready       (sample_ch.ready),
        .in_sample      (sample_ch.sample_in),
        .out_valid      (result_ch.valid),
        .out_ready      (result_ch.ready),
        .out_sample     (result_ch.sample_out),
        .out_saturated  (result_ch.saturated),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .pready         (pready),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // result side backpressure
    initial
    begin
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            result_ch.ready <= no_gaps || ($urandom_range(0, 99) >= GAP_PCT);
        end
    end

    task automatic send_sample(input logic signed [SW-1:0] x);
        while (!no_gaps && $urandom_range(0, 99) < GAP_PCT)
        begin
            sample_ch.valid <= 1'b0;
            @(posedge clk);
        end
        sample_ch.valid     <= 1'b1;
        sample_ch.sample_in <= x;
        @(posedge clk);
        while (!sample_ch.ready)
            @(posedge clk);
    endtask

    task automatic apb_write_coef(input logic [2:0] idx, input logic [DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic load_coefs(input logic [DATA_W-1:0] nb0, input logic [DATA_W-1:0] nb1,
                              input logic [DATA_W-1:0] nb2, input logic [DATA_W-1:0] na1,
                              input logic [DATA_W-1:0] na2);
        apb_write_coef(REG_B0, nb0);
        apb_write_coef(REG_B1, nb1);
        apb_write_coef(REG_B2, nb2);
        apb_write_coef(REG_A1, na1);
        apb_write_coef(REG_A2, na2);
    endtask

    // stop feeding and wait for every result to come back
    task automatic drain();
        sample_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    initial
    begin
        int                   c [5];
        int                   lim;
        int                   pick;
        logic signed [SW-1:0] x;

        rst_n               <= 1'b0;
        no_gaps             <= 1'b0;
        sample_ch.valid     <= 1'b0;
        sample_ch.sample_in <= '0;
        psel                <= 1'b0;
        penable             <= 1'b0;
        pwrite              <= 1'b0;
        paddr               <= '0;
        pwdata              <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset coefficients pass samples through unchanged
        send_sample(16'sd0);
        send_sample(16'sd32767);
        send_sample(-16'sd32768);
        send_sample(16'sd1);
        send_sample(-16'sd1);
        send_sample(16'h5555);
        send_sample(16'hAAAA);
        drain();

        // b0 = 0.5: exact half LSB ties round upward
        load_coefs(UNITY / 2, 0, 0, 0, 0);
        send_sample(16'sd1);
        send_sample(-16'sd1);
        send_sample(16'sd3);
        send_sample(-16'sd3);
        drain();

        // extreme coefficients, junk above bit 17, then writes to unmapped slots
        load_coefs({14'h3FFF, 18'h1FFFF}, {14'h0000, 18'h20000}, {14'h2AAA, 18'h1FFFF},
                   {14'h1555, 18'h20000}, {14'h3FFF, 18'h1FFFF});
        for (int i = NUM_REGS; i < 8; i++)
            apb_write_coef(3'(i), '1);
        send_sample(16'sd32767);
        send_sample(-16'sd32768);
        send_sample(16'sd32767);
        send_sample(-16'sd32768);
        send_sample(16'sd0);
        send_sample(16'sd0);
        drain();

        // accumulator y = x + y1: saturated value must be what feeds back
        load_coefs(UNITY, 0, 0, -UNITY, 0);
        send_sample(16'sd20000);
        send_sample(16'sd20000);
        send_sample(-16'sd32768);
        send_sample(-16'sd32768);
        send_sample(-16'sd32768);
        send_sample(16'sd100);
        drain();

        for (int k = 0; k < RAND_PHASES; k++)
        begin
            no_gaps <= (k == QUIET_PHASE);
            case (k % 3)
                0:
                begin
                    for (int i = 0; i < 5; i++)
                        c[i] = $urandom;
                end
                1:
                begin
                    // stable biquad so outputs stay mostly in range
                    c[4] = $urandom_range(0, 14000);
                    lim  = (UNITY + c[4]) * 9 / 10;
                    c[3] = int'($urandom_range(0, 2 * lim)) - lim;
                    for (int i = 0; i < 3; i++)
                        c[i] = int'($urandom_range(0, UNITY)) - UNITY / 2;
                end
                default:
                begin
                    for (int i = 0; i < 5; i++)
                    begin
                        case ($urandom_range(0, 3))
                            0:       c[i] = COEF_MAX;
                            1:       c[i] = COEF_MIN;
                            2:       c[i] = 0;
                            default: c[i] = UNITY;
                        endcase
                    end
                end
            endcase
            load_coefs(c[0], c[1], c[2], c[3], c[4]);
            if ($urandom_range(0, 3) == 0)
                apb_write_coef(3'($urandom_range(NUM_REGS, 7)), $urandom);

            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                pick = $urandom_range(0, 9);
                if (pick < 6)
                    x = SW'($urandom);
                else if (pick < 9)
                    x = SW'(int'($urandom_range(0, 4000)) - 2000);
                else
                    x = $urandom_range(0, 1) ? 16'sd32767 : -16'sd32768;
                send_sample(x);
            end
            drain();
        end

        repeat (5) @(posedge clk);
        if (mismatch_count == 0 && outstanding == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
